/* rtl/dgif_pkg.sv */
// shared types and constants of the graphics-interface dma channel
`default_nettype none
package dgif_pkg;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [31:0] ADDR_CHAN_CTRL = 32'h1000_A000;
  localparam logic [31:0] ADDR_CHAN_MADR = 32'h1000_A010;
  localparam logic [31:0] ADDR_CHAN_QWC  = 32'h1000_A020;
  localparam logic [31:0] ADDR_D_CTRL    = 32'h1000_E000;
  localparam logic [31:0] ADDR_D_STAT    = 32'h1000_E010;

  localparam int unsigned START_BIT = 8;
  localparam logic [31:0] QWORD_BYTES = 32'd16;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] address;
    logic [31:0] write_data;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        fetch_valid;
    logic [31:0] fetch_address;
    logic        transfer_done;
  } result_t;

endpackage
`default_nettype wire

/* rtl/dgif_if.sv */
// valid/ready channel interfaces for bus transactions and results
`default_nettype none
interface dgif_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] address;
  logic [31:0] write_data;

  modport source (output valid, output action, output address, output write_data,
                  input ready);
  modport sink (input valid, input action, input address, input write_data,
                output ready);
endinterface

interface dgif_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        fetch_valid;
  logic [31:0] fetch_address;
  logic        transfer_done;

  modport source (output valid, output read_data, output fetch_valid,
                  output fetch_address, output transfer_done, input ready);
  modport sink (input valid, input read_data, input fetch_valid,
                input fetch_address, input transfer_done, output ready);
endinterface
`default_nettype wire

/* rtl/dgif_in_reg.sv */
// input register for incoming transactions
`default_nettype none
module dgif_in_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  dgif_in_if.sink            in_bus,
  input  wire logic          advance,
  output logic               item_valid,
  output dgif_pkg::item_t    item
);
  import dgif_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  take;

  assign in_bus.ready = !valid_r || advance;
  assign take         = in_bus.valid && in_bus.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.action     <= in_bus.action;
      item_r.address    <= in_bus.address;
      item_r.write_data <= in_bus.write_data;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule
`default_nettype wire

/* rtl/dgif_core.sv */
// register file, bus decode and transfer tick logic of the channel
`default_nettype none
module dgif_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          exec,
  input  wire dgif_pkg::item_t item,
  output dgif_pkg::result_t  result
);
  import dgif_pkg::*;

  logic        master_enable_r, master_enable_nxt;
  logic        cycle_steal_r, cycle_steal_nxt;
  logic [1:0]  drain_channel_r, drain_channel_nxt;
  logic [1:0]  stall_source_r, stall_source_nxt;
  logic [1:0]  stall_dest_r, stall_dest_nxt;
  logic [2:0]  release_cycle_r, release_cycle_nxt;
  logic [31:0] chan_control_r, chan_control_nxt;
  logic [31:0] chan_address_r, chan_address_nxt;
  logic [15:0] chan_count_r, chan_count_nxt;
  logic [9:0]  chan_int_masks_r, chan_int_masks_nxt;
  logic        stall_int_mask_r, stall_int_mask_nxt;
  logic        fifo_int_mask_r, fifo_int_mask_nxt;
  logic        fetch_go;
  logic [15:0] count_dec;

  assign fetch_go = master_enable_r && chan_control_r[START_BIT] &&
                    (chan_control_r[3:2] == 2'd0);
  assign count_dec = chan_count_r - 16'd1;

  always_comb begin
    master_enable_nxt  = master_enable_r;
    cycle_steal_nxt    = cycle_steal_r;
    drain_channel_nxt  = drain_channel_r;
    stall_source_nxt   = stall_source_r;
    stall_dest_nxt     = stall_dest_r;
    release_cycle_nxt  = release_cycle_r;
    chan_control_nxt   = chan_control_r;
    chan_address_nxt   = chan_address_r;
    chan_count_nxt     = chan_count_r;
    chan_int_masks_nxt = chan_int_masks_r;
    stall_int_mask_nxt = stall_int_mask_r;
    fifo_int_mask_nxt  = fifo_int_mask_r;
    result             = '0;

    case (item.action)
      ACT_READ: begin
        case (item.address)
          ADDR_CHAN_CTRL: result.read_data = chan_control_r;
          ADDR_D_CTRL: result.read_data = {21'd0, release_cycle_r, stall_dest_r,
                                           stall_source_r, drain_channel_r,
                                           cycle_steal_r, master_enable_r};
          ADDR_D_STAT: result.read_data = {1'b0, fifo_int_mask_r, stall_int_mask_r,
                                           4'd0, chan_int_masks_r, 15'd0};
          default: result.read_data = '0;
        endcase
      end
      ACT_WRITE: begin
        case (item.address)
          ADDR_CHAN_CTRL: chan_control_nxt = item.write_data;
          ADDR_CHAN_MADR: chan_address_nxt = item.write_data;
          ADDR_CHAN_QWC:  chan_count_nxt   = item.write_data[15:0];
          ADDR_D_CTRL: begin
            master_enable_nxt = item.write_data[0];
            cycle_steal_nxt   = item.write_data[1];
            drain_channel_nxt = item.write_data[3:2];
            stall_source_nxt  = item.write_data[5:4];
            stall_dest_nxt    = item.write_data[7:6];
            release_cycle_nxt = item.write_data[10:8];
          end
          ADDR_D_STAT: begin
            chan_int_masks_nxt = chan_int_masks_r ^ item.write_data[24:15];
            stall_int_mask_nxt = stall_int_mask_r ^ item.write_data[29];
            fifo_int_mask_nxt  = fifo_int_mask_r ^ item.write_data[30];
          end
          default: ;
        endcase
      end
      ACT_TICK: begin
        if (fetch_go) begin
          result.fetch_valid   = 1'b1;
          result.fetch_address = chan_address_r;
          chan_address_nxt     = chan_address_r + QWORD_BYTES;
          chan_count_nxt       = count_dec;
          if (count_dec == 16'd0) begin
            chan_control_nxt[START_BIT] = 1'b0;
            result.transfer_done        = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_enable_r  <= 1'b0;
      cycle_steal_r    <= 1'b0;
      drain_channel_r  <= '0;
      stall_source_r   <= '0;
      stall_dest_r     <= '0;
      release_cycle_r  <= '0;
      chan_control_r   <= '0;
      chan_address_r   <= '0;
      chan_count_r     <= '0;
      chan_int_masks_r <= '0;
      stall_int_mask_r <= 1'b0;
      fifo_int_mask_r  <= 1'b0;
    end else if (exec) begin
      master_enable_r  <= master_enable_nxt;
      cycle_steal_r    <= cycle_steal_nxt;
      drain_channel_r  <= drain_channel_nxt;
      stall_source_r   <= stall_source_nxt;
      stall_dest_r     <= stall_dest_nxt;
      release_cycle_r  <= release_cycle_nxt;
      chan_control_r   <= chan_control_nxt;
      chan_address_r   <= chan_address_nxt;
      chan_count_r     <= chan_count_nxt;
      chan_int_masks_r <= chan_int_masks_nxt;
      stall_int_mask_r <= stall_int_mask_nxt;
      fifo_int_mask_r  <= fifo_int_mask_nxt;
    end
  end

  a_done_clears_start: assert property (@(posedge clk) disable iff (!rst_n)
    exec && result.transfer_done |=> !chan_control_r[START_BIT])
    else $error("start bit still set after last fetch");

  a_fetch_steps_address: assert property (@(posedge clk) disable iff (!rst_n)
    exec && result.fetch_valid |=>
      chan_address_r == $past(chan_address_r) + QWORD_BYTES)
    else $error("address did not advance by one quadword");

  a_fetch_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    result.fetch_valid |-> item.action == ACT_TICK && result.read_data == '0)
    else $error("fetch issued outside a tick");

endmodule
`default_nettype wire

/* rtl/dgif_out_reg.sv */
// result register with ready backpressure
`default_nettype none
module dgif_out_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire dgif_pkg::result_t result,
  output logic                 advance,
  dgif_out_if.source           out_bus
);
  import dgif_pkg::*;

  logic    valid_r, valid_nxt;
  result_t result_r;

  assign advance = !valid_r || out_bus.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_bus.valid         = valid_r;
  assign out_bus.read_data     = result_r.read_data;
  assign out_bus.fetch_valid   = result_r.fetch_valid;
  assign out_bus.fetch_address = result_r.fetch_address;
  assign out_bus.transfer_done = result_r.transfer_done;

endmodule
`default_nettype wire

/* rtl/dma_controller_gif_channel_core.sv */
// top level of the graphics-interface dma channel register block
// One transaction (bus read, bus write or transfer tick) is taken per clock while
// the input is ready; it is held first in the input register, then the decode and
// register update settle into the result register. The input stays
// ready while the result register is empty or being drained, so a stalled result
// holds up at most one further transaction. Register state updates as each
// transaction leaves the input register, so back-to-back transactions see each
// other's writes in order.
`default_nettype none
module dma_controller_gif_channel_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dgif_in_if.sink    in_bus,
  dgif_out_if.source out_bus
);
  import dgif_pkg::*;

  logic    item_valid;
  item_t   item;
  result_t result;
  logic    advance;
  logic    exec;

  assign exec = item_valid && advance;

  dgif_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  dgif_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .exec   (exec),
    .item   (item),
    .result (result)
  );

  dgif_out_reg u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (exec),
    .result  (result),
    .advance (advance),
    .out_bus (out_bus)
  );

endmodule
`default_nettype wire
